// ----- hdl/sdt_pkg.sv -----
// Shared types and constants for the stream delimiter tokenizer.
// Used by sdt_out and stream_delimiter_tokenizer.
package sdt_pkg;

	// Default window depth, the largest delimiter the window can hold.
	localparam int MAX_DELIM_DEF = 8;

	// Configuration register indexes and their reset values.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_LEN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES = 1'b1;
	localparam logic [3:0]  DELIM_LEN_RST   = 4'd1;
	localparam logic [63:0] DELIM_BYTES_RST = 64'd44;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_FLUSH,
		ST_DONE
	} state_t;

	// One token byte handed from the sequencer to the output stage.
	typedef struct packed {
		logic       valid;
		logic [7:0] ch;
		logic       last;
	} emit_t;

endpackage

// ----- hdl/sdt_match.sv -----
// Shared window compare unit: checks the window against the delimiter prefix.
// Depends on sdt_pkg only through the instantiating top level.
module sdt_match #(
	parameter int MAX_DELIM = 8,
	parameter int FILL_W    = 4
) (
	input  logic [MAX_DELIM*8-1:0] win,
	input  logic [FILL_W-1:0]      fill,
	input  logic [3:0]             len,
	input  logic [63:0]            delim_bytes,
	output logic                   ok
);

	localparam int CMP_W = (FILL_W > 4) ? FILL_W : 4;

	// The window is a delimiter prefix when it is no longer than the delimiter
	// and every valid byte equals the delimiter byte at the same place.
	always_comb begin
		ok = (CMP_W'(fill) <= CMP_W'(len));
		for (int i = 0; i < MAX_DELIM; i++) begin
			if ((CMP_W'(i) < CMP_W'(fill)) &&
			    (win[i*8 +: 8] != delim_bytes[(i % 8)*8 +: 8])) begin
				ok = 1'b0;
			end
		end
	end

endmodule

// ----- hdl/sdt_out.sv -----
// Output stage: one pending word and one output register with stall.
// The pending word learns its run_last flag when the next word or the end of
// the item arrives. Depends on sdt_pkg.
module sdt_out (
	input  logic          clk,
	input  logic          arst_n,
	input  sdt_pkg::emit_t req,
	input  logic          fin,
	output logic          ready,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_char,
	output logic          token_last,
	output logic          run_last
);

	logic       pend_valid_q;
	logic [7:0] pend_char_q;
	logic       pend_last_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       token_last_q;
	logic       run_last_q;
	logic       out_free;
	logic       push_new;
	logic       push_fin;

	// A word may move out when the output register is empty or being taken.
	assign out_free = !out_valid_q || !out_stall;
	assign ready    = !pend_valid_q || out_free;
	assign push_new = req.valid && ready;
	assign push_fin = fin && ready && pend_valid_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_new) begin
				pend_valid_q <= 1'b1;
			end else if (push_fin) begin
				pend_valid_q <= 1'b0;
			end
			if ((push_new && pend_valid_q) || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (push_new) begin
			pend_char_q <= req.ch;
			pend_last_q <= req.last;
			if (pend_valid_q) begin
				out_char_q   <= pend_char_q;
				token_last_q <= pend_last_q;
				run_last_q   <= 1'b0;
			end
		end else if (push_fin) begin
			out_char_q   <= pend_char_q;
			token_last_q <= pend_last_q;
			run_last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign token_last = token_last_q;
	assign run_last   = run_last_q;

endmodule

// ----- hdl/stream_delimiter_tokenizer.sv -----
// Top level of the stream delimiter tokenizer: sequencer, match window, config.
// Depends on sdt_pkg, sdt_match and sdt_out.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | ch, is_end
//  output  | out_valid | out_stall | out_char, token_last, run_last
//
// An item steps through accept, load, scan, flush and done; no new word is taken
// until it is done. Load first shifts a byte out of a full window, scan shifts
// out bytes until the window is a delimiter prefix, flush shifts out each byte
// at end of string; the MAX_DELIM-byte window and its single compare unit set these shifts.
// Output stalls hold the sequencer only on steps that emit a word or finish the item.
// Reset empties the window, drops the held byte and loads the configuration
// reset values; the input stalls while reset is asserted.
module stream_delimiter_tokenizer #(
	parameter int MAX_DELIM = sdt_pkg::MAX_DELIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  ch,
	input  logic                        is_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_char,
	output logic                        token_last,
	output logic                        run_last,
	input  logic                        cfg_we,
	input  logic [sdt_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [63:0]                 cfg_data
);

	localparam int FILL_W  = $clog2(MAX_DELIM + 1);
	localparam int LEN_CAP = (MAX_DELIM < 8) ? MAX_DELIM : 8;

	sdt_pkg::state_t state_q, state_d;
	logic [3:0]  delim_len_q;
	logic [63:0] delim_bytes_q;
	logic [7:0]  win_q [MAX_DELIM];
	logic [MAX_DELIM*8-1:0] win_flat;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]  held_char_q;
	logic        held_valid_q;
	logic [7:0]  ch_q;
	logic        end_q;
	logic [3:0]  len;
	logic        match_ok;
	logic        full_match;
	logic        ready;
	logic        go;
	logic        do_shift;
	logic        do_append;
	logic        do_clear;
	logic        fin;
	sdt_pkg::emit_t emit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_len_q   <= sdt_pkg::DELIM_LEN_RST;
			delim_bytes_q <= sdt_pkg::DELIM_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				sdt_pkg::REG_DELIM_LEN:   delim_len_q   <= cfg_data[3:0];
				sdt_pkg::REG_DELIM_BYTES: delim_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective delimiter length, clamped to the supported range.
	always_comb begin
		len = delim_len_q;
		if (len == 4'd0) begin
			len = 4'd1;
		end
		if (len > 4'(LEN_CAP)) begin
			len = 4'(LEN_CAP);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_DELIM; i++) begin
			win_flat[i*8 +: 8] = win_q[i];
		end
	end

	sdt_match #(
		.MAX_DELIM (MAX_DELIM),
		.FILL_W    (FILL_W)
	) u_match (
		.win         (win_flat),
		.fill        (fill_q),
		.len         (len),
		.delim_bytes (delim_bytes_q),
		.ok          (match_ok)
	);

	assign full_match = match_ok && ({1'b0, fill_q} == (FILL_W + 1)'(len));

	// Actions of the current step.
	always_comb begin
		do_shift  = 1'b0;
		do_append = 1'b0;
		do_clear  = 1'b0;
		fin       = 1'b0;
		emit      = '0;
		case (state_q)
			sdt_pkg::ST_LOAD: begin
				if ({1'b0, fill_q} >= (FILL_W + 1)'(MAX_DELIM)) begin
					do_shift = 1'b1;
				end else begin
					do_append = 1'b1;
				end
			end
			sdt_pkg::ST_SCAN: begin
				if (fill_q != '0) begin
					if (full_match) begin
						do_clear = 1'b1;
						emit.last = 1'b1;
					end else if (!match_ok) begin
						do_shift = 1'b1;
					end
				end
			end
			sdt_pkg::ST_FLUSH: begin
				if (end_q) begin
					if (fill_q != '0) begin
						do_shift = 1'b1;
					end else begin
						do_clear = 1'b1;
						emit.last = 1'b1;
					end
				end
			end
			sdt_pkg::ST_DONE: begin
				fin = 1'b1;
			end
			default: ;
		endcase
		// Shifting or clearing sends out the held byte if there is one.
		emit.valid = (do_shift || do_clear) && held_valid_q;
		emit.ch    = held_char_q;
	end

	assign go       = !(emit.valid || fin) || ready;
	assign in_stall = !arst_n || (state_q != sdt_pkg::ST_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sdt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = sdt_pkg::ST_LOAD;
				end
			end
			sdt_pkg::ST_LOAD: begin
				if (go && do_append) begin
					state_d = sdt_pkg::ST_SCAN;
				end
			end
			sdt_pkg::ST_SCAN: begin
				if (go && !do_shift) begin
					state_d = sdt_pkg::ST_FLUSH;
				end
			end
			sdt_pkg::ST_FLUSH: begin
				if (go && !do_shift) begin
					state_d = sdt_pkg::ST_DONE;
				end
			end
			sdt_pkg::ST_DONE: begin
				if (go) begin
					state_d = sdt_pkg::ST_IDLE;
				end
			end
			default: state_d = sdt_pkg::ST_IDLE;
		endcase
	end

	// Control state: sequencer, window fill and held flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sdt_pkg::ST_IDLE;
			fill_q       <= '0;
			held_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (go) begin
				if (do_shift) begin
					fill_q       <= fill_q - 1'b1;
					held_valid_q <= 1'b1;
				end else if (do_append) begin
					fill_q <= fill_q + 1'b1;
				end else if (do_clear) begin
					fill_q       <= '0;
					held_valid_q <= 1'b0;
				end
			end
		end
	end

	// Payload: captured word, window bytes and held byte.
	always_ff @(posedge clk) begin
		if (state_q == sdt_pkg::ST_IDLE && in_valid) begin
			ch_q  <= ch;
			end_q <= is_end;
		end
		if (go && do_shift) begin
			held_char_q <= win_q[0];
			for (int i = 0; i < MAX_DELIM - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
		end else if (go && do_append) begin
			for (int i = 0; i < MAX_DELIM; i++) begin
				if (FILL_W'(i) == fill_q) begin
					win_q[i] <= ch_q;
				end
			end
		end
	end

	sdt_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (emit),
		.fin        (fin),
		.ready      (ready),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_char   (out_char),
		.token_last (token_last),
		.run_last   (run_last)
	);

endmodule

// ----- hdl/sdt_checker.sv -----
// Port-level checks for the stream delimiter tokenizer, bound to the top level.
// Depends on stream_delimiter_tokenizer ports only.
module sdt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       token_last,
	input logic       run_last
);

	// The block works on one word at a time, so it stalls right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while the previous word is in flight");

	// While a result that is not the last of its run is shown, the word that
	// caused it is still being worked on, so no new word is taken.
	a_busy_until_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !run_last) |-> in_stall)
		else $error("new word taken before the last result of the run");

	// A stalled result stays valid.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output valid dropped under stall");

	// A stalled result keeps its payload.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		($stable(out_char) && $stable(token_last) && $stable(run_last)))
		else $error("output payload changed under stall");

endmodule

bind stream_delimiter_tokenizer sdt_checker u_sdt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_char   (out_char),
	.token_last (token_last),
	.run_last   (run_last)
);
